// ----- design/ulist_pkg.sv -----
// Shared types and constants for the unsorted list block.
package ulist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OUT_CNT_W = 5;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic    load;        // capture the accepted item
    logic    write_ins;   // append value at the count, bump count
    logic    scan;        // issue one search read, check previous one
    logic    rd_last;     // read the last stored entry
    logic    write_move;  // move last entry into the hole, drop count
    logic    res_load;    // load the result register
    status_t res_status;
  } ulist_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    op_t  kind;
    logic full;
    logic empty;
    logic hit;
    logic last;
  } ulist_sts_t;

endpackage

// ----- design/ulist_dp.sv -----
// Datapath of the unsorted list: entry memory, count, search pointer, result.
module ulist_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  ulist_pkg::ulist_cmd_t              cmd,
  output ulist_pkg::ulist_sts_t              sts,
  input  logic                               in_kind,
  input  logic signed [ulist_pkg::DATA_W-1:0] in_value,
  output logic [2:0]                         res_status,
  output logic [ulist_pkg::OUT_CNT_W-1:0]    res_count
);

  logic [ulist_pkg::DATA_W-1:0] mem [ulist_pkg::CAPACITY];
  logic [ulist_pkg::DATA_W-1:0] rd_data;
  logic [ulist_pkg::DATA_W-1:0] value_reg;
  ulist_pkg::op_t               kind_reg;
  logic [ulist_pkg::CNT_W-1:0]  fill;
  logic [ulist_pkg::CNT_W-1:0]  scan_ptr;
  logic [ulist_pkg::IDX_W-1:0]  cmp_idx;
  logic                         cmp_valid;
  logic [ulist_pkg::IDX_W-1:0]  hit_idx;

  logic [ulist_pkg::CNT_W-1:0]  fill_m1;
  logic [ulist_pkg::IDX_W-1:0]  last_idx;
  logic [ulist_pkg::IDX_W-1:0]  rd_addr;
  logic                         issue;
  logic                         wr_en;
  logic [ulist_pkg::IDX_W-1:0]  wr_addr;
  logic [ulist_pkg::DATA_W-1:0] wr_data;
  logic [ulist_pkg::CNT_W+ulist_pkg::OUT_CNT_W-1:0] fill_ext;

  assign fill_m1  = fill - ulist_pkg::CNT_W'(1);
  assign last_idx = fill_m1[ulist_pkg::IDX_W-1:0];
  assign rd_addr  = cmd.rd_last ? last_idx : scan_ptr[ulist_pkg::IDX_W-1:0];
  assign issue    = cmd.scan && (scan_ptr < fill);

  assign wr_en   = cmd.write_ins || cmd.write_move;
  assign wr_addr = cmd.write_move ? hit_idx : fill[ulist_pkg::IDX_W-1:0];
  assign wr_data = cmd.write_move ? rd_data : value_reg;

  assign sts.kind  = kind_reg;
  assign sts.full  = (fill == ulist_pkg::CNT_W'(ulist_pkg::CAPACITY));
  assign sts.empty = (fill == '0);
  assign sts.hit   = cmp_valid && (rd_data == value_reg);
  assign sts.last  = cmp_valid && (cmp_idx == last_idx);

  assign fill_ext = {{ulist_pkg::OUT_CNT_W{1'b0}}, fill};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      scan_ptr  <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_ptr  <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan) begin
        scan_ptr  <= issue ? scan_ptr + ulist_pkg::CNT_W'(1) : scan_ptr;
        cmp_valid <= issue;
      end
      if (cmd.write_ins) begin
        fill <= fill + ulist_pkg::CNT_W'(1);
      end else if (cmd.write_move) begin
        fill <= fill_m1;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_reg <= in_value;
      kind_reg  <= ulist_pkg::op_t'(in_kind);
    end
    if (cmd.scan) begin
      cmp_idx <= scan_ptr[ulist_pkg::IDX_W-1:0];
      if (sts.hit) begin
        hit_idx <= cmp_idx;
      end
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_count  <= fill_ext[ulist_pkg::OUT_CNT_W-1:0];
    end
  end

endmodule

// ----- design/ulist_ctrl.sv -----
// Controller of the unsorted list: sequences insert, search and move.
module ulist_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ulist_pkg::ulist_sts_t sts,
  output ulist_pkg::ulist_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_LAST_RD,
    S_MOVE,
    S_DONE
  } state_t;

  state_t               state;
  ulist_pkg::status_t   status_reg;
  logic                 res_free;

  assign in_ready = (state == S_IDLE);
  assign res_free = !out_valid || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.res_status = status_reg;
    unique case (state)
      S_IDLE:    cmd.load       = in_valid;
      S_DECIDE:  cmd.write_ins  = (sts.kind == ulist_pkg::OP_INSERT) && !sts.full;
      S_SCAN:    cmd.scan       = 1'b1;
      S_LAST_RD: cmd.rd_last    = 1'b1;
      S_MOVE:    cmd.write_move = 1'b1;
      S_DONE:    cmd.res_load   = res_free;
      default:   cmd            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      status_reg <= ulist_pkg::ST_INSERTED;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state <= S_DONE;
          if (sts.kind == ulist_pkg::OP_INSERT) begin
            status_reg <= sts.full ? ulist_pkg::ST_FULL : ulist_pkg::ST_INSERTED;
          end else if (sts.empty) begin
            status_reg <= ulist_pkg::ST_EMPTY;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // first match wins over end of list
          if (sts.hit) begin
            state <= S_LAST_RD;
          end else if (sts.last) begin
            status_reg <= ulist_pkg::ST_NOT_FOUND;
            state      <= S_DONE;
          end
        end
        S_LAST_RD: begin
          state <= S_MOVE;
        end
        S_MOVE: begin
          status_reg <= ulist_pkg::ST_DELETED;
          state      <= S_DONE;
        end
        S_DONE: begin
          // hold until the result register is free
          if (res_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/unsorted_list_insert_delete.sv -----
// Unsorted list of up to 16 signed 32-bit values with insert and delete by value.
// Items are taken one at a time. An insert, a rejected insert and a delete on an
// empty list go from acceptance through a decide step to the result. A delete scans
// the stored entries through the single read port of the entry memory, one entry
// per cycle; a hit adds a read of the last entry and a write into the hole. A
// result that waits on out_ready holds the block in its done state. The next item
// is accepted in the cycle after the result is loaded, even while that result
// still waits on out_ready. Entries hold no reset value; only indices below the
// count are ever compared.
module unsorted_list_insert_delete (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               kind,
  input  logic signed [ulist_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         status,
  output logic [ulist_pkg::OUT_CNT_W-1:0]    count
);

  ulist_pkg::ulist_cmd_t cmd;
  ulist_pkg::ulist_sts_t sts;

  ulist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ulist_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_kind    (kind),
    .in_value   (value),
    .res_status (status),
    .res_count  (count)
  );

  // Never append to a full list.
  a_no_ins_full: assert property (@(posedge clk) disable iff (rst)
    cmd.write_ins |-> !sts.full)
    else $error("insert write on full list");

  // A move into the hole always follows the read of the last entry.
  a_move_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.write_move |-> $past(cmd.rd_last))
    else $error("move without last entry read");

  // One item at a time: no acceptance right after an acceptance.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  // A new result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the unsorted list insert/delete block.
module tb;
  import ulist_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef struct {
    op_t         kind;
    logic [31:0] value;
    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          drain;
    bit          hold;
  } list_op_t;

  typedef struct packed {
    status_t              status;
    logic [OUT_CNT_W-1:0] count;
  } list_result_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    kind = 1'b0;
  logic signed [DATA_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [2:0]              status;
  logic [OUT_CNT_W-1:0]    count;

  list_op_t     pending_ops[$];
  list_result_t results_due[$];

  // Mirror of the list contents, updated on every accepted item.
  logic [31:0] mirror_entries[CAPACITY];
  int unsigned mirror_fill = 0;

  int unsigned total_items = 0;
  int unsigned items_accepted = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_start = 1'b0;

  unsorted_list_insert_delete i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .count     (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void apply_list_op(op_t op, logic [31:0] v);
    list_result_t res;
    int unsigned  pos;
    pos = 0;
    if (op == OP_INSERT) begin
      if (mirror_fill >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        mirror_entries[mirror_fill] = v;
        mirror_fill++;
        res.status = ST_INSERTED;
      end
    end else if (mirror_fill == 0) begin
      res.status = ST_EMPTY;
    end else begin
      while (pos < mirror_fill && mirror_entries[pos] != v) pos++;
      if (pos < mirror_fill) begin
        // Fill the hole with the last entry.
        mirror_entries[pos] = mirror_entries[mirror_fill - 1];
        mirror_fill--;
        res.status = ST_DELETED;
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
    res.count = mirror_fill[OUT_CNT_W-1:0];
    results_due.push_back(res);
  endfunction

  function automatic void queue_op(op_t k, logic [31:0] v, int unsigned idle,
                                   int unsigned stall, bit drain, bit hold);
    list_op_t op;
    op.kind      = k;
    op.value     = v;
    op.idle_pct  = idle;
    op.stall_pct = stall;
    op.drain     = drain;
    op.hold      = hold;
    pending_ops.push_back(op);
    total_items++;
  endfunction

  task automatic report_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch on result %0d: %s got %0d, expected %0d",
             results_seen, field, got, want);
    error_count++;
  endtask

  // Driver: offer items from the pending queue.
  always @(posedge clk) begin
    list_op_t head;
    logic     took;
    logic     launch;
    logic     hold_pulse;
    took       = in_valid && in_ready;
    launch     = 1'b0;
    hold_pulse = 1'b0;
    if (rst) begin
      in_valid   <= 1'b0;
      hold_start <= 1'b0;
    end else begin
      if (took) begin
        apply_list_op(op_t'(kind), value);
        items_accepted <= items_accepted + 1;
      end
      if (!(in_valid && !took) && pending_ops.size() != 0) begin
        head = pending_ops[0];
        // Hold a draining item until every result is back.
        if (head.drain && (took || items_accepted != results_seen)) launch = 1'b0;
        else if ($urandom_range(99) < head.idle_pct) launch = 1'b0;
        else launch = 1'b1;
      end
      if (launch) begin
        void'(pending_ops.pop_front());
        kind       <= head.kind;
        value      <= head.value;
        stall_pct  <= head.stall_pct;
        hold_pulse = head.hold;
        in_valid   <= 1'b1;
      end else if (!(in_valid && !took)) begin
        in_valid <= 1'b0;
      end
      hold_start <= hold_pulse;
    end
  end

  // Long receiver hold-off.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Monitor: check each result against the oldest expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("unexpected result: status %0d count %0d", status, count);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (count !== want.count) report_mismatch("count", count, want.count);
        end
        results_seen <= results_seen + 1;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] pool[6];
    int unsigned done_items;
    int unsigned seg_len;
    int unsigned ins_pct;
    int unsigned idle;
    int unsigned stall;
    int unsigned phase;
    int unsigned last_phase;
    bit          drain_seg;
    bit          hold_seg;
    op_t         k;
    logic [31:0] v;

    // Directed: empty, extremes, duplicates, miss, last slot, full.
    queue_op(OP_DELETE, 32'h0000_0005, 0, 0, 0, 0);
    queue_op(OP_INSERT, 32'h8000_0000, 0, 0, 0, 0);
    queue_op(OP_INSERT, 32'h7FFF_FFFF, 0, 0, 0, 0);
    queue_op(OP_INSERT, 32'h0000_0000, 0, 0, 0, 0);
    queue_op(OP_INSERT, 32'hFFFF_FFFF, 0, 0, 0, 0);
    queue_op(OP_INSERT, 32'h7FFF_FFFF, 0, 0, 0, 0);
    queue_op(OP_DELETE, 32'h1234_5678, 0, 0, 0, 0);
    queue_op(OP_DELETE, 32'h7FFF_FFFF, 0, 0, 0, 0);
    queue_op(OP_DELETE, 32'hFFFF_FFFF, 0, 0, 0, 0);
    for (int i = 0; i < CAPACITY - 3; i++)
      queue_op(OP_INSERT, 32'h0101_0101 * (i + 1), 0, 0, 0, 0);
    queue_op(OP_INSERT, 32'h5555_AAAA, 0, 0, 0, 0);
    queue_op(OP_DELETE, 32'h8000_0000, 0, 0, 0, 0);
    queue_op(OP_DELETE, 32'hAAAA_5555, 0, 0, 0, 0);

    // Random segments: each has its own value pool and insert bias.
    done_items = 0;
    last_phase = 4;
    while (done_items < RANDOM_ITEMS) begin
      phase   = done_items * 4 / RANDOM_ITEMS;
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(2))
        0: ins_pct = 75;
        1: ins_pct = 30;
        default: ins_pct = 50;
      endcase
      foreach (pool[p]) pool[p] = $urandom;
      if ($urandom_range(3) == 0) pool[0] = 32'h8000_0000;
      if ($urandom_range(3) == 0) pool[1] = 32'h7FFF_FFFF;
      case (phase)
        0: begin idle = 0;  stall = 0;  end
        1: begin idle = 59; stall = 0;  end
        2: begin idle = 0;  stall = 59; end
        default: begin idle = 32; stall = 32; end
      endcase
      if (phase != 0 && $urandom_range(3) == 0) begin
        idle  = 0;
        stall = 0;
      end
      drain_seg = (phase != last_phase) || ($urandom_range(5) == 0);
      hold_seg  = (phase != last_phase) && (phase == 1 || phase == 3);
      last_phase = phase;
      for (int i = 0; i < seg_len; i++) begin
        k = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE;
        v = ($urandom_range(9) < 8) ? pool[$urandom_range(5)] : 32'($urandom);
        queue_op(k, v, idle, stall, drain_seg && i == 0, hold_seg && i == 0);
      end
      done_items += seg_len;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && items_accepted == total_items);
    wait (results_seen == items_accepted);
    repeat (SETTLE) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0d results never arrived", results_due.size());
      error_count++;
    end
    if (error_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
